### design/mrfc_pkg.sv
// mrfc_pkg: shared types and constants of the motor reply frame checker
// no dependencies; imported by every mrfc module and the top level
package mrfc_pkg;

    localparam int FRAME_LEN = 13;
    localparam int POS_W = $clog2(FRAME_LEN + 1);
    localparam int HDR_LEN = 4;
    localparam int HSUM_IDX = 4;
    localparam int TEMP_IDX = 5;
    localparam int TORQUE_IDX = 6;
    localparam int SPEED_IDX = 8;
    localparam int ENC_IDX = 10;
    localparam int DSUM_IDX = 12;

    localparam logic [7:0] HEAD_RESET = 8'h3E;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    typedef logic [7:0] frame_t [FRAME_LEN];

    typedef struct packed {
        logic       wr;
        logic       clr;
        logic [7:0] data;
    } fs_ctrl_t;

    typedef struct packed {
        logic               ok;
        logic signed [7:0]  temperature;
        logic signed [15:0] torque_or_power;
        logic signed [15:0] speed;
        logic [15:0]        encoder;
    } check_t;

endpackage

### design/mrfc_frame_store.sv
// mrfc_frame_store: 13-byte reply frame store with fill position
// depends on mrfc_pkg
module mrfc_frame_store (
    input  logic              clk,
    input  logic              rst_n,
    input  mrfc_pkg::fs_ctrl_t ctrl,
    output mrfc_pkg::frame_t   frame
);
    import mrfc_pkg::*;

    logic [7:0]       frame_reg [FRAME_LEN];
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             room;

    assign room = (pos_reg < POS_W'(FRAME_LEN));

    always_comb
    begin
        pos_next = pos_reg;
        if (ctrl.clr)
        begin
            pos_next = '0;
        end
        else if (ctrl.wr && room)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int i = 0; i < FRAME_LEN; i++)
            begin
                frame_reg[i] <= '0;
            end
        end
        else
        begin
            pos_reg <= pos_next;
            for (int i = 0; i < FRAME_LEN; i++)
            begin
                if (ctrl.clr)
                begin
                    frame_reg[i] <= '0;
                end
                else if (ctrl.wr && room && pos_reg == POS_W'(i))
                begin
                    frame_reg[i] <= ctrl.data;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            frame[i] = frame_reg[i];
        end
    end

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(FRAME_LEN))
        else $error("fill position past frame end");

    a_clr_restart: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clr |=> (pos_reg == '0 && frame_reg[0] == 8'h00))
        else $error("frame store not cleared after check");

endmodule

### design/mrfc_check.sv
// mrfc_check: head and checksum test of the stored frame, field extraction
// depends on mrfc_pkg
module mrfc_check (
    input  mrfc_pkg::frame_t frame,
    input  logic [7:0]       head_byte,
    output mrfc_pkg::check_t chk
);
    import mrfc_pkg::*;

    logic [7:0] hsum;
    logic [7:0] dsum;

    always_comb
    begin
        hsum = '0;
        for (int i = 0; i < HDR_LEN; i++)
        begin
            hsum = hsum + frame[i];
        end
        dsum = '0;
        for (int i = TEMP_IDX; i < DSUM_IDX; i++)
        begin
            dsum = dsum + frame[i];
        end
    end

    always_comb
    begin
        chk.ok = (frame[0] == head_byte) && (frame[HSUM_IDX] == hsum)
                 && (frame[DSUM_IDX] == dsum);
        chk.temperature = frame[TEMP_IDX];
        chk.torque_or_power = {frame[TORQUE_IDX+1], frame[TORQUE_IDX]};
        chk.speed = {frame[SPEED_IDX+1], frame[SPEED_IDX]};
        chk.encoder = {frame[ENC_IDX+1], frame[ENC_IDX]};
    end

endmodule

### design/mrfc_result.sv
// mrfc_result: latched motor values, check and failure counters, result register
// depends on mrfc_pkg
module mrfc_result (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  mrfc_pkg::check_t chk,
    input  logic             out_ready,
    output logic             out_valid,
    output logic             reply_ok,
    output mrfc_pkg::check_t last,
    output logic [31:0]      check_count,
    output logic [31:0]      fail_count
);
    import mrfc_pkg::*;

    logic        valid_reg;
    logic        ok_reg;
    check_t      last_reg;
    logic [31:0] checks_reg;
    logic [31:0] fails_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ok_reg <= 1'b0;
            last_reg <= '0;
            checks_reg <= '0;
            fails_reg <= '0;
        end
        else
        begin
            if (fire)
            begin
                valid_reg <= 1'b1;
                ok_reg <= chk.ok;
                checks_reg <= checks_reg + 32'd1;
                if (chk.ok)
                begin
                    last_reg <= chk;
                end
                else
                begin
                    fails_reg <= fails_reg + 32'd1;
                end
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = valid_reg;
    assign reply_ok = ok_reg;
    assign last = last_reg;
    assign check_count = checks_reg;
    assign fail_count = fails_reg;

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> checks_reg == $past(checks_reg) + 32'd1)
        else $error("check count did not step");

    a_fail_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !chk.ok) |=> (fails_reg == $past(fails_reg) + 32'd1 && !ok_reg))
        else $error("failure not counted");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(checks_reg)
                                      && $stable(fails_reg) && $stable(last_reg)))
        else $error("result changed while stalled");

endmodule

### design/motor_reply_frame_checker.sv
// motor_reply_frame_checker: top level, input register and head byte register
// depends on mrfc_pkg, mrfc_frame_store, mrfc_check, mrfc_result
//
//  group   dir  fields (low bit first)
//  s_*     in   tuser: cmd; tdata: rx_byte
//  m_*     out  tuser: reply_ok; tdata: temperature, torque_or_power, speed,
//                encoder, check_count, fail_count
//  cfg     in   head_byte_we, head_byte_wdata
//
//  one beat per cycle sustained while no check beat waits on a stalled m_*; each beat passes the input register
//  a check beat gives its result on m_* the cycle after it leaves the input register
//  a byte beat gives no result and moves on even while m_* is stalled
//  a check beat waits in the input register while an earlier result is not taken
//  reset clears the frame store, counters and latched values; head_byte resets to 0x3e
module motor_reply_frame_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // rx_byte
    input  logic         s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // temperature, torque_or_power, speed, encoder,
                                    // check_count, fail_count
    output logic         m_tuser,   // reply_ok
    input  logic         head_byte_we,
    input  logic [7:0]   head_byte_wdata
);
    import mrfc_pkg::*;

    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;
    logic [7:0] head_reg;
    logic       out_valid;
    logic       advance;
    logic       chk_fire;
    fs_ctrl_t   fs_ctrl;
    frame_t     frame;
    check_t     chk;
    check_t     last;
    logic       reply_ok;
    logic [31:0] check_count;
    logic [31:0] fail_count;

    assign advance = in_valid_reg && (in_cmd_reg == CMD_BYTE || !out_valid || m_tready);
    assign chk_fire = advance && in_cmd_reg == CMD_CHECK;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            head_reg <= HEAD_RESET;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (head_byte_we)
            begin
                head_reg <= head_byte_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    always_comb
    begin
        fs_ctrl.wr = advance && in_cmd_reg == CMD_BYTE;
        fs_ctrl.clr = chk_fire;
        fs_ctrl.data = in_byte_reg;
    end

    mrfc_frame_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (fs_ctrl),
        .frame (frame)
    );

    mrfc_check u_check (
        .frame     (frame),
        .head_byte (head_reg),
        .chk       (chk)
    );

    mrfc_result u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (chk_fire),
        .chk         (chk),
        .out_ready   (m_tready),
        .out_valid   (out_valid),
        .reply_ok    (reply_ok),
        .last        (last),
        .check_count (check_count),
        .fail_count  (fail_count)
    );

    assign m_tvalid = out_valid;
    assign m_tuser = reply_ok;
    assign m_tdata = {fail_count, check_count, last.encoder, last.speed,
                      last.torque_or_power, last.temperature};

    a_check_result: assert property (@(posedge clk) disable iff (!rst_n)
        chk_fire |=> m_tvalid)
        else $error("check beat gave no result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !chk_fire)
        else $error("result overwritten while stalled");

endmodule

### verif/mrfc_reply_checker.sv
// mrfc_reply_checker: watches both streams and the head byte write port of the
// motor reply frame checker, predicts each reply and compares it with the block
// depends on mrfc_pkg
module mrfc_reply_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,   // rx_byte
    input  logic         s_tuser,   // cmd
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [119:0] m_tdata,   // temperature, torque_or_power, speed, encoder,
                                    // check_count, fail_count
    input  logic         m_tuser,   // reply_ok
    input  logic         head_byte_we,
    input  logic [7:0]   head_byte_wdata,
    output int           mismatches,
    output int           replies_due
);
    import mrfc_pkg::*;

    typedef struct packed {
        check_t      status;
        logic [31:0] checks;
        logic [31:0] fails;
    } reply_t;

    frame_t             frame_bytes;
    logic [POS_W-1:0]   fill_pos;
    logic [7:0]         head;
    logic signed [7:0]  held_temp;
    logic signed [15:0] held_torque;
    logic signed [15:0] held_speed;
    logic [15:0]        held_encoder;
    logic [31:0]        checks_done;
    logic [31:0]        failures_done;
    reply_t             reply_q [$];
    reply_t             want;
    reply_t             seen;
    int                 err_total;

    function automatic reply_t evaluate_frame();
        reply_t     r;
        logic [7:0] hsum;
        logic [7:0] dsum;
        logic       ok;
        hsum = '0;
        dsum = '0;
        for (int i = 0; i < HDR_LEN; i++)
            hsum += frame_bytes[i];
        for (int i = TEMP_IDX; i < DSUM_IDX; i++)
            dsum += frame_bytes[i];
        ok = (frame_bytes[0] == head) && (frame_bytes[HSUM_IDX] == hsum)
            && (frame_bytes[DSUM_IDX] == dsum);
        if (ok)
        begin
            held_temp    = frame_bytes[TEMP_IDX];
            held_torque  = {frame_bytes[TORQUE_IDX + 1], frame_bytes[TORQUE_IDX]};
            held_speed   = {frame_bytes[SPEED_IDX + 1], frame_bytes[SPEED_IDX]};
            held_encoder = {frame_bytes[ENC_IDX + 1], frame_bytes[ENC_IDX]};
        end
        checks_done++;
        if (!ok)
            failures_done++;
        for (int i = 0; i < FRAME_LEN; i++)
            frame_bytes[i] = '0;
        fill_pos = '0;
        r.status.ok              = ok;
        r.status.temperature     = held_temp;
        r.status.torque_or_power = held_torque;
        r.status.speed           = held_speed;
        r.status.encoder         = held_encoder;
        r.checks                 = checks_done;
        r.fails                  = failures_done;
        return r;
    endfunction

    task automatic flag_field(string field, longint expected, longint actual);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected, actual);
        err_total++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_LEN; i++)
                frame_bytes[i] = '0;
            fill_pos      = '0;
            head          = HEAD_RESET;
            held_temp     = '0;
            held_torque   = '0;
            held_speed    = '0;
            held_encoder  = '0;
            checks_done   = '0;
            failures_done = '0;
            err_total     = 0;
            reply_q.delete();
            mismatches  <= 0;
            replies_due <= 0;
        end
        else
        begin
            if (head_byte_we)
                head = head_byte_wdata;
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == CMD_CHECK)
                    reply_q.push_back(evaluate_frame());
                else if (fill_pos < FRAME_LEN)
                begin
                    frame_bytes[fill_pos] = s_tdata;
                    fill_pos++;
                end
            end
            if (m_tvalid && m_tready)
            begin
                seen = {m_tuser, m_tdata[7:0], m_tdata[23:8], m_tdata[39:24],
                        m_tdata[55:40], m_tdata[87:56], m_tdata[119:88]};
                if (reply_q.size() == 0)
                begin
                    $display("%0t: reply beat with none expected, expected none, actual %h",
                             $time, seen);
                    err_total++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (want.status.ok !== seen.status.ok)
                        flag_field("reply_ok", want.status.ok, seen.status.ok);
                    if (want.status.temperature !== seen.status.temperature)
                        flag_field("temperature", want.status.temperature,
                                   seen.status.temperature);
                    if (want.status.torque_or_power !== seen.status.torque_or_power)
                        flag_field("torque_or_power", want.status.torque_or_power,
                                   seen.status.torque_or_power);
                    if (want.status.speed !== seen.status.speed)
                        flag_field("speed", want.status.speed, seen.status.speed);
                    if (want.status.encoder !== seen.status.encoder)
                        flag_field("encoder", want.status.encoder, seen.status.encoder);
                    if (want.checks !== seen.checks)
                        flag_field("check_count", want.checks, seen.checks);
                    if (want.fails !== seen.fails)
                        flag_field("fail_count", want.fails, seen.fails);
                end
            end
            replies_due <= reply_q.size();
            mismatches  <= err_total;
        end
    end

endmodule

### verif/motor_reply_frame_checker_test.sv
// motor_reply_frame_checker_test: drives reply bytes, check requests and head byte
// settings into the frame checker, with bursty input and a stalling output side
// depends on mrfc_pkg, motor_reply_frame_checker and mrfc_reply_checker
module motor_reply_frame_checker_test;
    import mrfc_pkg::*;

    localparam int RANDOM_ITEMS  = 1250;
    localparam int PHASES        = 5;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 6;

    typedef enum int {
        SEQ_GOOD,
        SEQ_BAD_HEAD,
        SEQ_BAD_HSUM,
        SEQ_BAD_DSUM,
        SEQ_SHORT,
        SEQ_LONG,
        SEQ_NOISE
    } seq_kind_e;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;
    logic         m_tuser;
    logic         head_byte_we = 1'b0;
    logic [7:0]   head_byte_wdata = '0;

    int           mismatches;
    int           replies_due;
    int           items_sent = 0;
    int           burst_left = 0;
    int           quiet_cycles = 0;
    int           hold_req = 0;
    logic [7:0]   head_now = HEAD_RESET;

    always #6 clk = ~clk;

    motor_reply_frame_checker uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .head_byte_we    (head_byte_we),
        .head_byte_wdata (head_byte_wdata)
    );

    mrfc_reply_checker reply_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .head_byte_we    (head_byte_we),
        .head_byte_wdata (head_byte_wdata),
        .mismatches      (mismatches),
        .replies_due     (replies_due)
    );

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_beat(logic cmd, logic [7:0] value, bit counted);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (counted)
            items_sent++;
        pace();
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (replies_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_head(logic [7:0] value);
        head_byte_we    <= 1'b1;
        head_byte_wdata <= value;
        @(posedge clk);
        head_byte_we <= 1'b0;
        head_now = value;
    endtask

    task automatic send_sequence(seq_kind_e kind);
        logic [7:0] fb [FRAME_LEN];
        logic [7:0] total;
        int         len;
        if (kind == SEQ_NOISE)
        begin
            repeat ($urandom_range(1, 6))
                send_beat($urandom_range(0, 1) ? CMD_CHECK : CMD_BYTE, pick_byte(), 1'b1);
            return;
        end
        fb[0] = head_now;
        if (kind == SEQ_BAD_HEAD)
            fb[0] = head_now ^ 8'($urandom_range(1, 255));
        total = fb[0];
        for (int i = 1; i < HDR_LEN; i++)
        begin
            fb[i] = pick_byte();
            total += fb[i];
        end
        fb[HSUM_IDX] = total;
        total = '0;
        for (int i = TEMP_IDX; i < DSUM_IDX; i++)
        begin
            fb[i] = pick_byte();
            total += fb[i];
        end
        fb[DSUM_IDX] = total;
        if (kind == SEQ_BAD_HSUM)
            fb[HSUM_IDX] ^= 8'($urandom_range(1, 255));
        if (kind == SEQ_BAD_DSUM)
            fb[DSUM_IDX] ^= 8'($urandom_range(1, 255));
        len = FRAME_LEN;
        if (kind == SEQ_SHORT)
            len = $urandom_range(0, FRAME_LEN - 1);
        if (kind == SEQ_LONG)
            len = FRAME_LEN + $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
            send_beat(CMD_BYTE, (i < FRAME_LEN) ? fb[i] : pick_byte(), i < FRAME_LEN);
        send_beat(CMD_CHECK, pick_byte(), 1'b1);
    endtask

    task automatic run_phase(int quota, bit with_hold);
        int        start;
        int        r;
        bit        held;
        seq_kind_e kind;
        start = items_sent;
        held  = 1'b0;
        while (items_sent - start < quota)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                kind = SEQ_GOOD;
            else if (r < 68)
                kind = SEQ_BAD_HEAD;
            else if (r < 74)
                kind = SEQ_BAD_HSUM;
            else if (r < 80)
                kind = SEQ_BAD_DSUM;
            else if (r < 87)
                kind = SEQ_SHORT;
            else if (r < 93)
                kind = SEQ_LONG;
            else
                kind = SEQ_NOISE;
            send_sequence(kind);
            if (with_hold && !held && (items_sent - start >= quota / 4))
            begin
                hold_req <= hold_req + 1;
                held = 1'b1;
            end
        end
    endtask

    initial
    begin
        int hold_seen;
        int stretch;
        int mode;
        int period;
        hold_seen = 0;
        wait (rst_n);
        forever
        begin
            mode    = $urandom_range(0, 3);
            period  = $urandom_range(2, 5);
            stretch = $urandom_range(20, 200);
            while (stretch > 0 && hold_seen == hold_req)
            begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 9) < 7);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (stretch % period == 0);
                endcase
                @(posedge clk);
                stretch--;
            end
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] extreme_frame [FRAME_LEN];
        logic [7:0] phase_head;
        extreme_frame = '{8'h3E, 8'hFF, 8'h00, 8'h80, 8'hBD, 8'h80, 8'hFF,
                          8'h7F, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'h7C};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // check on an empty store, then a full frame with field extremes
        send_beat(CMD_CHECK, 8'hFF, 1'b1);
        foreach (extreme_frame[i])
            send_beat(CMD_BYTE, extreme_frame[i], 1'b1);
        send_beat(CMD_BYTE, 8'h55, 1'b0);
        send_beat(CMD_CHECK, 8'h00, 1'b1);
        // short frame
        send_beat(CMD_BYTE, HEAD_RESET, 1'b1);
        send_beat(CMD_BYTE, 8'h00, 1'b1);
        send_beat(CMD_CHECK, 8'h00, 1'b1);
        settle();
        // a cleared store matches a zero head
        write_head(8'h00);
        send_beat(CMD_CHECK, 8'h00, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       phase_head = 8'hFF;
                2:       phase_head = 8'h00;
                3:       phase_head = HEAD_RESET;
                default: phase_head = 8'($urandom_range(0, 255));
            endcase
            settle();
            write_head(phase_head);
            run_phase(RANDOM_ITEMS / PHASES, (p == 1) || (p == 3));
        end
        settle();

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
